### rtl/msb_first_bit_packer_defines.svh
// ----------------------------------------------------------------------------
// msb_first_bit_packer_defines.svh
// Assertion macros used by the bit packer RTL.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define MBP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbp assertion failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define MBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbp assertion failed");

`endif

### rtl/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Types and constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int MAX_CODE_BITS = 32;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 6;
  localparam int ACC_W         = 40;
  localparam int LIMIT_W       = 25;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;
  // Count cap: the lesser of the code limit and the width of value.
  localparam logic [COUNT_W-1:0] CODE_CAP    =
    COUNT_W'((MAX_CODE_BITS < VALUE_W) ? MAX_CODE_BITS : VALUE_W);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT,
    S_OUT
  } state_t;

  // Sequencer to shift unit.
  typedef struct packed {
    logic load;
    logic step;
  } unit_ctrl_t;

  // Shift unit back to sequencer.
  typedef struct packed {
    logic       has_byte;
    logic       last;
    logic [7:0] byte_val;
    logic [2:0] tail_count;
    logic [7:0] tail_bits;
  } unit_stat_t;

endpackage

### rtl/mbp_shift_unit.sv
// ----------------------------------------------------------------------------
// mbp_shift_unit
// Accumulator with one shared barrel shifter that extracts bytes MSB first.
// ----------------------------------------------------------------------------
module mbp_shift_unit (
  input  logic                        clk,
  input  mbp_pkg::unit_ctrl_t         ctrl,
  input  logic [7:0]                  pend_bits,
  input  logic [mbp_pkg::COUNT_W-1:0] shift_n,
  input  logic [mbp_pkg::VALUE_W-1:0] code,
  input  logic [mbp_pkg::COUNT_W-1:0] total,
  output mbp_pkg::unit_stat_t         stat
);

  logic [mbp_pkg::ACC_W-1:0]   acc;
  logic [mbp_pkg::COUNT_W-1:0] remaining;
  logic [mbp_pkg::COUNT_W-1:0] rem_after;
  logic [mbp_pkg::COUNT_W-1:0] shamt;
  logic [mbp_pkg::ACC_W-1:0]   shifted;
  logic                        has_byte;

  assign has_byte  = (remaining >= mbp_pkg::COUNT_W'(8));
  assign shamt     = remaining - mbp_pkg::COUNT_W'(8);
  assign shifted   = acc >> shamt;
  assign rem_after = has_byte ? shamt : remaining;

  always_comb begin
    stat.has_byte   = has_byte;
    stat.last       = (remaining < mbp_pkg::COUNT_W'(16));
    stat.byte_val   = shifted[7:0];
    stat.tail_count = rem_after[2:0];
    stat.tail_bits  = acc[7:0] & ~(8'hFF << rem_after[2:0]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc       <= ({32'd0, pend_bits} << shift_n) | {8'd0, code};
      remaining <= total;
    end else if (ctrl.step && has_byte) begin
      remaining <= shamt;
    end
  end

endmodule

### rtl/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// Sequence: a taken request enters CHECK, which judges it against the limit;
//   each byte is then formed in EMIT and offered in OUT, and an overflow
//   result goes from CHECK straight to OUT. An item emits 1..4 bytes, none for
//   a write with no byte or a flush with nothing pending; output stalls hold OUT.
//   The shared shifter yields one byte per EMIT/OUT pair; a new request waits for IDLE.
// Reset: rst (sync, high) clears pending bits and byte count, byte_limit 16777216.
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs 1..32 bit codes MSB first into bytes, with flush and byte limit.
// ----------------------------------------------------------------------------
`include "msb_first_bit_packer_defines.svh"

module msb_first_bit_packer (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: byte limit
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mbp_pkg::LIMIT_W-1:0] cfg_data,
  // input requests
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [mbp_pkg::COUNT_W-1:0] bit_count,
  input  logic [mbp_pkg::VALUE_W-1:0] value,
  // result requests
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        last_of_run,
  output logic                        overflow,
  output logic [mbp_pkg::LIMIT_W-1:0] bytes_written
);

  mbp_pkg::state_t state, state_next;

  // Architectural state.
  logic [mbp_pkg::LIMIT_W-1:0] byte_limit;
  logic [7:0]                  pending_bits;
  logic [2:0]                  pending_count;
  logic [mbp_pkg::LIMIT_W-1:0] byte_total;

  // Captured request.
  logic [mbp_pkg::COUNT_W-1:0] code_n;
  logic [mbp_pkg::VALUE_W-1:0] code_v;
  logic                        skip;

  // Capture path: saturate the count, mask stray value bits, size a flush.
  logic [mbp_pkg::COUNT_W-1:0] n_sat;
  logic [mbp_pkg::COUNT_W-1:0] n_in;
  logic [mbp_pkg::VALUE_W-1:0] v_in;

  // Limit check.
  logic [mbp_pkg::COUNT_W-1:0] total;
  logic [mbp_pkg::LIMIT_W:0]   total_after;
  logic                        too_many;

  mbp_pkg::unit_ctrl_t ctrl;
  mbp_pkg::unit_stat_t stat;

  logic in_take;
  logic out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    n_sat = (bit_count > mbp_pkg::CODE_CAP) ? mbp_pkg::CODE_CAP : bit_count;
    if (operation == mbp_pkg::OP_FLUSH) begin
      n_in = mbp_pkg::COUNT_W'(4'd8 - {1'b0, pending_count});
      v_in = '0;
    end else begin
      n_in = n_sat;
      if (n_sat >= mbp_pkg::COUNT_W'(mbp_pkg::VALUE_W)) begin
        v_in = value;
      end else begin
        v_in = value & ~({mbp_pkg::VALUE_W{1'b1}} << n_sat);
      end
    end
  end

  // The whole item is judged at once: bytes it would complete vs the limit.
  assign total       = mbp_pkg::COUNT_W'(pending_count) + code_n;
  assign total_after = {1'b0, byte_total} + (mbp_pkg::LIMIT_W+1)'(total[5:3]);
  assign too_many    = total_after > {1'b0, byte_limit};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mbp_pkg::S_IDLE: begin
        if (in_take) state_next = mbp_pkg::S_CHECK;
      end
      mbp_pkg::S_CHECK: begin
        if (skip)          state_next = mbp_pkg::S_IDLE;
        else if (too_many) state_next = mbp_pkg::S_OUT;
        else               state_next = mbp_pkg::S_EMIT;
      end
      mbp_pkg::S_EMIT: begin
        if (stat.has_byte) state_next = mbp_pkg::S_OUT;
        else               state_next = mbp_pkg::S_IDLE;
      end
      mbp_pkg::S_OUT: begin
        if (out_take) state_next = last_of_run ? mbp_pkg::S_IDLE : mbp_pkg::S_EMIT;
      end
      default: state_next = mbp_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = (state == mbp_pkg::S_IDLE);
    out_valid = (state == mbp_pkg::S_OUT);
    ctrl.load = (state == mbp_pkg::S_CHECK) && !skip && !too_many;
    ctrl.step = (state == mbp_pkg::S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mbp_pkg::S_IDLE;
      byte_limit    <= mbp_pkg::LIMIT_RESET;
      pending_bits  <= '0;
      pending_count <= '0;
      byte_total    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) byte_limit <= cfg_data;
      // Advance the count per byte; drop the used bits once the tail is known.
      if (state == mbp_pkg::S_EMIT) begin
        if (stat.has_byte) byte_total <= byte_total + mbp_pkg::LIMIT_W'(1);
        if (stat.last) begin
          pending_count <= stat.tail_count;
          pending_bits  <= stat.tail_bits;
        end
      end
    end
  end

  // Request capture and result payload; valid bits come from the state.
  always_ff @(posedge clk) begin
    if (in_take) begin
      code_n <= n_in;
      code_v <= v_in;
      skip   <= (operation == mbp_pkg::OP_FLUSH) && (pending_count == 3'd0);
    end
    if (state == mbp_pkg::S_CHECK && too_many) begin
      out_byte      <= 8'd0;
      last_of_run   <= 1'b1;
      overflow      <= 1'b1;
      bytes_written <= byte_total;
    end else if (state == mbp_pkg::S_EMIT) begin
      out_byte      <= stat.byte_val;
      last_of_run   <= stat.last;
      overflow      <= 1'b0;
      bytes_written <= byte_total + mbp_pkg::LIMIT_W'(1);
    end
  end

  mbp_shift_unit u_shift (
    .clk       (clk),
    .ctrl      (ctrl),
    .pend_bits (pending_bits),
    .shift_n   (code_n),
    .code      (code_v),
    .total     (total),
    .stat      (stat)
  );

  // Never take a request while a result waits.
  `MBP_ASSERT_IMPL(a_no_overlap, in_ready, !out_valid)
  // An overflow result is a lone zero byte ending its run.
  `MBP_ASSERT_IMPL(a_ovf_shape, out_valid && overflow, last_of_run && (out_byte == 8'd0))
  // Handing over the last result frees the input side.
  `MBP_ASSERT_NEXT(a_last_frees, out_valid && out_ready && last_of_run, in_ready)

endmodule
